/* sv/vertical_horizontal_filter_macros.svh */
// Assertion helpers, clocked on clk and disabled in reset.
`ifndef VERTICAL_HORIZONTAL_FILTER_MACROS_SVH
`define VERTICAL_HORIZONTAL_FILTER_MACROS_SVH

// same-cycle implication
`define VHF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vhf assertion failed");

// next-cycle implication
`define VHF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vhf assertion failed");

`endif

/* sv/vhf_pkg.sv */
package vhf_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int HIST_DEPTH  = MAX_WINDOW + 1;
  localparam int PTR_W       = $clog2(HIST_DEPTH);
  localparam int LEN_W       = 7;
  localparam int SUM_W       = 40;
  localparam int FRAC_BITS   = 16;
  localparam int RATIO_W     = FRAC_BITS + 1;
  localparam int DIV_STEPS   = RATIO_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;

  localparam logic [LEN_W-1:0] WINDOW_RESET = LEN_W'(14);
  localparam logic REG_WINDOW_LENGTH = 1'b0;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [RATIO_W-1:0] ratio_t;
  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

/* sv/vhf_channels.sv */
interface vhf_sample_if;
  import vhf_pkg::*;
  logic    valid;
  logic    ready;
  sample_t price_sample;
  modport source (output valid, output price_sample, input ready);
  modport sink (input valid, input price_sample, output ready);
endinterface

interface vhf_result_if;
  import vhf_pkg::*;
  logic   valid;
  logic   ready;
  ratio_t ratio;
  logic   zero_variation;
  modport source (output valid, output ratio, output zero_variation, input ready);
  modport sink (input valid, input ratio, input zero_variation, output ready);
endinterface

/* sv/vhf_ram.sv */
module vhf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/vertical_horizontal_filter.sv */
// Vertical horizontal filter: takes one signed price sample per transfer and, once more
// than n samples have been seen, with n the effective window length (window_length
// clamped to 1..64), returns |max - min| / sum|diff| over the window as unsigned Q1.16
// (65536 = 1.0, larger ratios clamped to 1.0), or ratio 0 with zero_variation set when
// the sum is zero. Samples are taken only in idle: an item that gives a result keeps
// the block from taking the next sample until it has done n + 1 history reads through
// the single read port of the sample RAM, the registered read of that RAM, the
// bit-serial divider and the load of the output register, which a result still waiting
// in the output register holds off.
// A write to window_length in idle clears the warm-up count; write it only while the
// block is idle and no result is waiting.
`include "vertical_horizontal_filter_macros.svh"

module vertical_horizontal_filter (
  input  logic                      clk,
  input  logic                      rst,
  vhf_sample_if.sink                samples,
  vhf_result_if.source              results,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [vhf_pkg::ADDR_W-1:0] paddr,
  input  logic [vhf_pkg::DATA_W-1:0] pwdata,
  output logic [vhf_pkg::DATA_W-1:0] prdata,
  output logic                      pready
);

  import vhf_pkg::*;

  state_t state, state_next;

  logic [LEN_W-1:0] window_length;
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] seen, seen_next, seen_inc;
  ptr_t head, head_next, head_inc;
  ptr_t rd_ptr, rd_ptr_next;
  logic [LEN_W-1:0] iss_cnt, iss_cnt_next;
  logic ret_valid, ret_valid_next;
  logic [LEN_W-1:0] ret_age, ret_age_next;
  sample_t prev, prev_next, high, high_next, low, low_next;
  logic [SUM_W-1:0] sum, sum_next;
  logic [SUM_W:0] rem, rem_next, shifted;
  ratio_t quo, quo_next;
  logic [CNT_W-1:0] div_cnt, div_cnt_next;
  logic res_valid, res_valid_next;
  ratio_t res_ratio, res_ratio_next;
  logic res_zero, res_zero_next;

  logic cfg_wr, in_xfer, out_load;
  logic ram_re;
  sample_t ram_rdata;
  logic [SAMPLE_BITS:0] step_diff, step_abs, range_diff, range_abs;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_WINDOW_LENGTH);
  assign prdata = (paddr[2] == REG_WINDOW_LENGTH) ?
                  {{(DATA_W-LEN_W){1'b0}}, window_length} : '0;

  assign eff_len = (window_length == '0) ? LEN_W'(1) :
                   (window_length > LEN_W'(MAX_WINDOW)) ? LEN_W'(MAX_WINDOW) :
                   window_length;

  assign samples.ready          = (state == ST_IDLE);
  assign in_xfer                = samples.valid && samples.ready;
  assign results.valid          = res_valid;
  assign results.ratio          = res_ratio;
  assign results.zero_variation = res_zero;

  assign head_inc = (head == ptr_t'(HIST_DEPTH - 1)) ? '0 : head + ptr_t'(1);
  assign seen_inc = (seen < eff_len + LEN_W'(1)) ? seen + LEN_W'(1) : seen;

  vhf_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(HIST_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (in_xfer),
    .waddr(head_inc),
    .wdata(samples.price_sample),
    .re   (ram_re),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  assign step_diff  = {prev[SAMPLE_BITS-1], prev} - {ram_rdata[SAMPLE_BITS-1], ram_rdata};
  assign step_abs   = step_diff[SAMPLE_BITS] ? -step_diff : step_diff;
  assign range_diff = {high[SAMPLE_BITS-1], high} - {low[SAMPLE_BITS-1], low};
  assign range_abs  = range_diff[SAMPLE_BITS] ? -range_diff : range_diff;
  assign shifted    = (div_cnt == '0) ? rem : {rem[SUM_W-1:0], 1'b0};

  always_comb begin
    state_next     = state;
    seen_next      = seen;
    head_next      = head;
    rd_ptr_next    = rd_ptr;
    iss_cnt_next   = iss_cnt;
    ret_valid_next = 1'b0;
    ret_age_next   = ret_age;
    prev_next      = prev;
    high_next      = high;
    low_next       = low;
    sum_next       = sum;
    rem_next       = rem;
    quo_next       = quo;
    div_cnt_next   = div_cnt;
    res_ratio_next = res_ratio;
    res_zero_next  = res_zero;
    res_valid_next = res_valid && !results.ready;
    ram_re         = 1'b0;
    out_load       = 1'b0;

    case (state)
      ST_IDLE: begin
        if (cfg_wr) begin
          seen_next = '0;
        end else if (in_xfer) begin
          head_next = head_inc;
          seen_next = seen_inc;
          if (seen_inc > eff_len) begin
            rd_ptr_next  = head_inc;
            iss_cnt_next = '0;
            state_next   = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (iss_cnt <= eff_len) begin
          ram_re         = 1'b1;
          rd_ptr_next    = (rd_ptr == '0) ? ptr_t'(HIST_DEPTH - 1) : rd_ptr - ptr_t'(1);
          iss_cnt_next   = iss_cnt + LEN_W'(1);
          ret_valid_next = 1'b1;
          ret_age_next   = iss_cnt;
        end
        if (ret_valid) begin
          prev_next = ram_rdata;
          if (ret_age == '0) begin
            high_next = ram_rdata;
            low_next  = ram_rdata;
            sum_next  = '0;
          end else begin
            sum_next = sum + SUM_W'(step_abs[SAMPLE_BITS-1:0]);
            if (ret_age < eff_len) begin
              if (ram_rdata > high) high_next = ram_rdata;
              if (ram_rdata < low) low_next = ram_rdata;
            end
          end
          if (ret_age == eff_len) begin
            rem_next     = (SUM_W+1)'(range_abs[SAMPLE_BITS-1:0]);
            quo_next     = '0;
            div_cnt_next = '0;
            state_next   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (shifted >= {1'b0, sum}) begin
          rem_next = shifted - {1'b0, sum};
          quo_next = {quo[RATIO_W-2:0], 1'b1};
        end else begin
          rem_next = shifted;
          quo_next = {quo[RATIO_W-2:0], 1'b0};
        end
        div_cnt_next = div_cnt + CNT_W'(1);
        if (div_cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid || results.ready) begin
          out_load       = 1'b1;
          res_valid_next = 1'b1;
          res_zero_next  = (sum == '0);
          if (sum == '0) begin
            res_ratio_next = '0;
          end else if (quo > ratio_t'(1 << FRAC_BITS)) begin
            res_ratio_next = ratio_t'(1 << FRAC_BITS);
          end else begin
            res_ratio_next = quo;
          end
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_length <= WINDOW_RESET;
      seen          <= '0;
      head          <= '0;
      ret_valid     <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      seen      <= seen_next;
      head      <= head_next;
      ret_valid <= ret_valid_next;
      res_valid <= res_valid_next;
      if (cfg_wr) begin
        window_length <= pwdata[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr    <= rd_ptr_next;
    iss_cnt   <= iss_cnt_next;
    ret_age   <= ret_age_next;
    prev      <= prev_next;
    high      <= high_next;
    low       <= low_next;
    sum       <= sum_next;
    rem       <= rem_next;
    quo       <= quo_next;
    div_cnt   <= div_cnt_next;
    res_ratio <= res_ratio_next;
    res_zero  <= res_zero_next;
  end

  `VHF_ASSERT_NOW(a_seen_capped, 1'b1, seen <= eff_len + LEN_W'(1))
  `VHF_ASSERT_NEXT(a_due_scans, in_xfer && !cfg_wr && (seen >= eff_len), state == ST_SCAN)
  `VHF_ASSERT_NOW(a_rem_bound, (state == ST_DIV) && (sum != '0), (rem < ({sum, 1'b0})))
  `VHF_ASSERT_NEXT(a_zero_flag, out_load && (sum == '0), res_zero && (res_ratio == '0))
  `VHF_ASSERT_NOW(a_ratio_max, res_valid, res_ratio <= ratio_t'(1 << FRAC_BITS))

endmodule
